// ===== sv/pmet_pkg.sv =====
// ----------------------------------------------------------------------------
// Peer misbehavior exclusion table package
// Shared types, register codes and control records for the table blocks.
// ----------------------------------------------------------------------------
package pmet_pkg;

  localparam int unsigned AddrW  = 64;
  localparam int unsigned TickW  = 48;
  localparam int unsigned ScoreW = 16;
  localparam int unsigned SpanW  = 24;
  localparam int unsigned ShareW = 9;
  localparam int unsigned PeersW = 16;
  localparam int unsigned OccW   = 9;
  localparam int unsigned ProdW  = SpanW + ScoreW;
  localparam int unsigned LimW   = PeersW + ShareW - 8;
  localparam int unsigned PaddrW = 4;
  localparam int unsigned PdataW = 32;

  localparam logic [1:0] REG_SCORE_THRESHOLD = 2'd0;
  localparam logic [1:0] REG_EXCLUSION_SPAN  = 2'd1;
  localparam logic [1:0] REG_FORGET_SPAN     = 2'd2;
  localparam logic [1:0] REG_PEER_SHARE_Q8   = 2'd3;

  localparam logic [ScoreW-1:0] ScoreMax = '1;

  typedef enum logic [1:0] {
    KIND_REPORT = 2'd0,
    KIND_CHECK  = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TRIM,
    ST_TSCAN,
    ST_EVICT,
    ST_SCAN,
    ST_MUL,
    ST_COMMIT
  } state_e;

  typedef struct packed {
    logic [ScoreW-1:0] score_threshold;
    logic [SpanW-1:0]  exclusion_span;
    logic [SpanW-1:0]  forget_span;
    logic [ShareW-1:0] peer_share_q8;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [AddrW-1:0]  addr_high;
    logic [AddrW-1:0]  addr_low;
    logic [TickW-1:0]  deadline;
    logic [ScoreW-1:0] score;
  } rec_t;

  typedef struct packed {
    logic load;
    logic scan_start;
    logic evict;
    logic mul;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic clear_busy;
    logic scan_done;
    logic trim_needed;
    logic out_busy;
  } sts_t;

endpackage

// ===== sv/pmet_item_if.sv =====
// ----------------------------------------------------------------------------
// Request channel
// Carries one table request beat with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pmet_item_if;
  logic                       valid;
  logic                       ready;
  logic [1:0]                 kind;
  logic [pmet_pkg::AddrW-1:0]  address_high;
  logic [pmet_pkg::AddrW-1:0]  address_low;
  logic [pmet_pkg::TickW-1:0]  now_ticks;
  logic [pmet_pkg::PeersW-1:0] network_peer_count;

  modport source (output valid, kind, address_high, address_low, now_ticks,
                  network_peer_count, input ready);
  modport sink (input valid, kind, address_high, address_low, now_ticks,
                network_peer_count, output ready);
endinterface

// ===== sv/pmet_result_if.sv =====
// ----------------------------------------------------------------------------
// Response channel
// Carries one table response beat with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface pmet_result_if;
  logic                       valid;
  logic                       ready;
  logic [pmet_pkg::ScoreW-1:0] peer_score;
  logic                       is_excluded;
  logic [pmet_pkg::OccW-1:0]   occupancy;

  modport source (output valid, peer_score, is_excluded, occupancy, input ready);
  modport sink (input valid, peer_score, is_excluded, occupancy, output ready);
endinterface

// ===== sv/pmet_ctrl.sv =====
// ----------------------------------------------------------------------------
// Table controller
// Sequences clearing, trimming scans, lookup scans, multiply and commit.
// ----------------------------------------------------------------------------
module pmet_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  pmet_pkg::sts_t sts_i,
  output pmet_pkg::cmd_t cmd_o
);

  pmet_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pmet_pkg::ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      pmet_pkg::ST_CLEAR: begin
        if (!sts_i.clear_busy) state_d = pmet_pkg::ST_IDLE;
      end
      pmet_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = pmet_pkg::ST_TRIM;
        end
      end
      pmet_pkg::ST_TRIM: begin
        cmd_o.scan_start = 1'b1;
        state_d = sts_i.trim_needed ? pmet_pkg::ST_TSCAN : pmet_pkg::ST_SCAN;
      end
      pmet_pkg::ST_TSCAN: begin
        if (sts_i.scan_done) state_d = pmet_pkg::ST_EVICT;
      end
      pmet_pkg::ST_EVICT: begin
        cmd_o.evict = 1'b1;
        state_d     = pmet_pkg::ST_TRIM;
      end
      pmet_pkg::ST_SCAN: begin
        if (sts_i.scan_done) state_d = pmet_pkg::ST_MUL;
      end
      pmet_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = pmet_pkg::ST_COMMIT;
      end
      pmet_pkg::ST_COMMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.commit = 1'b1;
          state_d      = pmet_pkg::ST_IDLE;
        end
      end
      default: state_d = pmet_pkg::ST_CLEAR;
    endcase
  end

endmodule

// ===== sv/pmet_dp.sv =====
// ----------------------------------------------------------------------------
// Table datapath
// Entry memory, scan pipeline, shared multiplier, update logic and result register.
// ----------------------------------------------------------------------------
module pmet_dp #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned AW          = $clog2(TABLE_DEPTH),
  parameter int unsigned CW          = $clog2(TABLE_DEPTH + 1)
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pmet_pkg::cfg_t               cfg_i,
  input  pmet_pkg::cmd_t               cmd_i,
  output pmet_pkg::sts_t               sts_o,
  input  logic [1:0]                   kind_i,
  input  logic [pmet_pkg::AddrW-1:0]   address_high_i,
  input  logic [pmet_pkg::AddrW-1:0]   address_low_i,
  input  logic [pmet_pkg::TickW-1:0]   now_ticks_i,
  input  logic [pmet_pkg::PeersW-1:0]  network_peer_count_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [pmet_pkg::ScoreW-1:0]  peer_score_o,
  output logic                         is_excluded_o,
  output logic [pmet_pkg::OccW-1:0]    occupancy_o,
  output logic [CW-1:0]                count_o
);

  localparam logic [AW-1:0] LastIdx = AW'(TABLE_DEPTH - 1);
  localparam logic [CW-1:0] Full    = CW'(TABLE_DEPTH);

  pmet_pkg::rec_t mem [TABLE_DEPTH];
  pmet_pkg::rec_t rd_q;

  logic [1:0]                  kind_q;
  logic [pmet_pkg::AddrW-1:0]  hi_q, lo_q;
  logic [pmet_pkg::TickW-1:0]  now_q;
  logic [pmet_pkg::LimW-1:0]   lim_q;
  logic [CW-1:0]               count_q, count_d;
  logic [pmet_pkg::PeersW+pmet_pkg::ShareW-1:0] share_prod;

  logic          clr_busy_q;
  logic [AW-1:0] clr_idx_q;
  logic          scan_act_q, dv_q;
  logic [AW-1:0] scan_idx_q, didx_q;

  logic                         m_found_q, free_found_q, best_found_q;
  logic [AW-1:0]                m_idx_q, free_idx_q, best_idx_q;
  logic [pmet_pkg::TickW-1:0]   m_dl_q, best_dl_q;
  logic [pmet_pkg::ScoreW-1:0]  m_score_q;
  logic [pmet_pkg::ProdW-1:0]   prod_q;

  logic                         out_valid_q, excl_q;
  logic [pmet_pkg::ScoreW-1:0]  score_q;
  logic [pmet_pkg::OccW-1:0]    occ_q;

  logic                         wr_en;
  logic [AW-1:0]                wr_addr;
  pmet_pkg::rec_t               wr_rec;
  logic                         c_wr;
  logic [AW-1:0]                c_addr;
  pmet_pkg::rec_t               c_rec;
  logic [pmet_pkg::ScoreW-1:0]  c_score, sc_inc, mul_b;
  logic                         c_excl;
  logic [pmet_pkg::SpanW-1:0]   mul_a;
  logic [pmet_pkg::TickW:0]     sum_base, sum_long, sum_forget;
  logic [pmet_pkg::TickW-1:0]   dl_base, dl_long, dl_new;
  logic                         is_report, scan_done;

  assign is_report = (kind_q == pmet_pkg::KIND_REPORT);
  assign scan_done = dv_q && (didx_q == LastIdx);

  assign share_prod = network_peer_count_i * cfg_i.peer_share_q8;

  assign sts_o.clear_busy  = clr_busy_q;
  assign sts_o.scan_done   = scan_done;
  assign sts_o.trim_needed = is_report && (count_q > CW'(1)) &&
                             (32'(count_q) > 32'(lim_q));
  assign sts_o.out_busy    = out_valid_q;

  always_ff @(posedge clk_i) begin
    rd_q <= mem[scan_idx_q];
    if (wr_en) mem[wr_addr] <= wr_rec;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      kind_q <= kind_i;
      hi_q   <= address_high_i;
      lo_q   <= address_low_i;
      now_q  <= now_ticks_i;
      lim_q  <= share_prod[pmet_pkg::PeersW+pmet_pkg::ShareW-1:8];
    end
    if (cmd_i.mul) prod_q <= mul_a * mul_b;
    if (cmd_i.commit) begin
      score_q <= c_score;
      excl_q  <= c_excl;
      occ_q   <= pmet_pkg::OccW'(count_d);
    end
    if (cmd_i.scan_start) begin
      m_found_q    <= 1'b0;
      free_found_q <= 1'b0;
      best_found_q <= 1'b0;
    end else if (dv_q) begin
      if (rd_q.valid) begin
        if (!m_found_q && rd_q.addr_high == hi_q && rd_q.addr_low == lo_q) begin
          m_found_q <= 1'b1;
          m_idx_q   <= didx_q;
          m_dl_q    <= rd_q.deadline;
          m_score_q <= rd_q.score;
        end
        if (!best_found_q || rd_q.deadline < best_dl_q) begin
          best_found_q <= 1'b1;
          best_idx_q   <= didx_q;
          best_dl_q    <= rd_q.deadline;
        end
      end else if (!free_found_q) begin
        free_found_q <= 1'b1;
        free_idx_q   <= didx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q  <= 1'b1;
      clr_idx_q   <= '0;
      scan_act_q  <= 1'b0;
      scan_idx_q  <= '0;
      dv_q        <= 1'b0;
      didx_q      <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (clr_busy_q) begin
        clr_idx_q <= clr_idx_q + AW'(1);
        if (clr_idx_q == LastIdx) clr_busy_q <= 1'b0;
      end
      dv_q   <= scan_act_q;
      didx_q <= scan_idx_q;
      if (cmd_i.scan_start) begin
        scan_act_q <= 1'b1;
        scan_idx_q <= '0;
      end else if (scan_act_q) begin
        scan_idx_q <= scan_idx_q + AW'(1);
        if (scan_idx_q == LastIdx) scan_act_q <= 1'b0;
      end
      if (cmd_i.evict) count_q <= count_q - CW'(1);
      else if (cmd_i.commit) count_q <= count_d;
      if (cmd_i.commit) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_comb begin
    sc_inc     = (m_score_q == pmet_pkg::ScoreMax) ? m_score_q
                                                   : m_score_q + pmet_pkg::ScoreW'(1);
    mul_a      = is_report ? cfg_i.exclusion_span : cfg_i.forget_span;
    mul_b      = is_report ? sc_inc : m_score_q;
    sum_base   = {1'b0, now_q} + (pmet_pkg::TickW+1)'(cfg_i.exclusion_span);
    sum_long   = {1'b0, now_q} + (pmet_pkg::TickW+1)'({prod_q, 1'b0});
    sum_forget = {1'b0, m_dl_q} + (pmet_pkg::TickW+1)'(prod_q);
    dl_base    = sum_base[pmet_pkg::TickW] ? '1 : sum_base[pmet_pkg::TickW-1:0];
    dl_long    = sum_long[pmet_pkg::TickW] ? '1 : sum_long[pmet_pkg::TickW-1:0];
    if (sc_inc == cfg_i.score_threshold) dl_new = dl_base;
    else if (sc_inc > cfg_i.score_threshold) dl_new = dl_long;
    else dl_new = m_dl_q;

    c_wr    = 1'b0;
    c_addr  = m_idx_q;
    c_rec   = '{valid: 1'b0, addr_high: hi_q, addr_low: lo_q,
                deadline: m_dl_q, score: m_score_q};
    c_score = '0;
    c_excl  = 1'b0;
    count_d = count_q;
    case (kind_q)
      pmet_pkg::KIND_REPORT: begin
        c_wr = 1'b1;
        if (m_found_q) begin
          c_rec   = '{valid: 1'b1, addr_high: hi_q, addr_low: lo_q,
                      deadline: dl_new, score: sc_inc};
          c_score = sc_inc;
        end else begin
          c_rec   = '{valid: 1'b1, addr_high: hi_q, addr_low: lo_q,
                      deadline: dl_base, score: pmet_pkg::ScoreW'(1)};
          c_score = pmet_pkg::ScoreW'(1);
          if (count_q >= Full) begin
            c_addr = best_idx_q;
          end else begin
            c_addr  = free_idx_q;
            count_d = count_q + CW'(1);
          end
        end
      end
      pmet_pkg::KIND_CHECK: begin
        if (m_found_q) begin
          c_score = m_score_q;
          if (m_score_q >= cfg_i.score_threshold) begin
            if (m_dl_q > now_q) begin
              c_excl = 1'b1;
            end else if (sum_forget < {1'b0, now_q}) begin
              c_wr    = 1'b1;
              count_d = count_q - CW'(1);
            end
          end
        end
      end
      pmet_pkg::KIND_REMOVE: begin
        if (m_found_q) begin
          c_wr    = 1'b1;
          count_d = count_q - CW'(1);
        end
      end
      default: c_wr = 1'b0;
    endcase

    wr_en   = 1'b0;
    wr_addr = c_addr;
    wr_rec  = c_rec;
    if (clr_busy_q) begin
      wr_en   = 1'b1;
      wr_addr = clr_idx_q;
      wr_rec  = '0;
    end else if (cmd_i.evict) begin
      wr_en   = 1'b1;
      wr_addr = best_idx_q;
      wr_rec  = '0;
    end else if (cmd_i.commit) begin
      wr_en   = c_wr;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign peer_score_o  = score_q;
  assign is_excluded_o = excl_q;
  assign occupancy_o   = occ_q;
  assign count_o       = count_q;

endmodule

// ===== sv/peer_misbehavior_exclusion_table.sv =====
// ----------------------------------------------------------------------------
// Peer misbehavior exclusion table
// Keeps scored, time-limited exclusion entries for misbehaving peer addresses.
// ----------------------------------------------------------------------------
// Requests arrive on item_i as report, check or remove beats; each request
// gives exactly one beat on result_o with the score, the exclusion flag and
// the table occupancy after the request. Registers are to be written over the
// APB port only while no request is in flight; the block does not enforce it.
// One request is worked at a time. A lookup scan reads every entry from the
// entry memory through its single read port. Before its lookup scan, a report
// may run trimming scans, each of which evicts one entry; check and remove do
// not trim. After reset a clearing pass marks every entry free; no request
// is taken during it, though register writes are.
// A finished response waits in the output register while the receiver
// stalls, and the next request can be accepted meanwhile; its own response
// is held back until the waiting beat is taken.
// ----------------------------------------------------------------------------
module peer_misbehavior_exclusion_table #(
  parameter int unsigned TABLE_DEPTH = 256
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  pmet_item_if.sink                     item_i,
  pmet_result_if.source                 result_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pmet_pkg::PaddrW-1:0]   paddr,
  input  logic [pmet_pkg::PdataW-1:0]   pwdata,
  output logic [pmet_pkg::PdataW-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

  pmet_pkg::cfg_t cfg_q;
  pmet_pkg::cmd_t cmd;
  pmet_pkg::sts_t sts;
  logic [CW-1:0]  count;
  logic           wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.score_threshold <= pmet_pkg::ScoreW'(2);
      cfg_q.exclusion_span  <= pmet_pkg::SpanW'(3600);
      cfg_q.forget_span     <= pmet_pkg::SpanW'(86400);
      cfg_q.peer_share_q8   <= pmet_pkg::ShareW'(128);
    end else if (wr_en) begin
      unique case (paddr[3:2])
        pmet_pkg::REG_SCORE_THRESHOLD:
          cfg_q.score_threshold <= pwdata[pmet_pkg::ScoreW-1:0];
        pmet_pkg::REG_EXCLUSION_SPAN:
          cfg_q.exclusion_span <= pwdata[pmet_pkg::SpanW-1:0];
        pmet_pkg::REG_FORGET_SPAN:
          cfg_q.forget_span <= pwdata[pmet_pkg::SpanW-1:0];
        pmet_pkg::REG_PEER_SHARE_Q8:
          cfg_q.peer_share_q8 <= pwdata[pmet_pkg::ShareW-1:0];
        default: cfg_q <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      pmet_pkg::REG_SCORE_THRESHOLD: prdata = pmet_pkg::PdataW'(cfg_q.score_threshold);
      pmet_pkg::REG_EXCLUSION_SPAN:  prdata = pmet_pkg::PdataW'(cfg_q.exclusion_span);
      pmet_pkg::REG_FORGET_SPAN:     prdata = pmet_pkg::PdataW'(cfg_q.forget_span);
      pmet_pkg::REG_PEER_SHARE_Q8:   prdata = pmet_pkg::PdataW'(cfg_q.peer_share_q8);
      default:                       prdata = '0;
    endcase
  end

  pmet_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (item_i.valid),
    .in_ready_o (item_i.ready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  pmet_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cfg_i                (cfg_q),
    .cmd_i                (cmd),
    .sts_o                (sts),
    .kind_i               (item_i.kind),
    .address_high_i       (item_i.address_high),
    .address_low_i        (item_i.address_low),
    .now_ticks_i          (item_i.now_ticks),
    .network_peer_count_i (item_i.network_peer_count),
    .out_valid_o          (result_o.valid),
    .out_ready_i          (result_o.ready),
    .peer_score_o         (result_o.peer_score),
    .is_excluded_o        (result_o.is_excluded),
    .occupancy_o          (result_o.occupancy),
    .count_o              (count)
  );

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(count) <= TABLE_DEPTH)
    else $error("entry count exceeds table depth");

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> !item_i.ready)
    else $error("request accepted while another is in flight");

  a_commit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.commit |-> !sts.out_busy)
    else $error("response overwrote a waiting beat");

  a_no_req_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sts.clear_busy |-> !item_i.ready)
    else $error("request taken during clearing pass");

endmodule
